>>> hdl/sbq_pkg.sv
package sbq_pkg;

  // Pool geometry
  localparam int QUEUE_SIZE = 32;
  localparam int IDX_W      = $clog2(QUEUE_SIZE);
  localparam int CNT_W      = $clog2(QUEUE_SIZE + 1);
  localparam int BLK_W      = 16;
  localparam int CNT_OUT_W  = 6;

  // Stream widths
  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 4;
  localparam int M_DATA_W = 40;

  // List numbers
  localparam logic [1:0] LST_HOST = 2'd0;
  localparam logic [1:0] LST_TLCW = 2'd1;
  localparam logic [1:0] LST_FREE = 2'd2;

  localparam logic [BLK_W-1:0] NO_BLOCK = '1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_DRAIN = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BAD_LIST = 3'd1,
    STS_FULL     = 3'd2,
    STS_BUSY     = 3'd3,
    STS_LOCKED   = 3'd4,
    STS_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_PUSH_WR,
    S_POP_WR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic rd_push;
    logic rd_pop;
    logic commit_push;
    logic commit_pop;
    logic emit_imm;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_push;
    logic go_pop;
    logic out_free;
    logic pop_last;
  } dp_stat_t;

endpackage

>>> hdl/shared_pool_block_queues.sv
// Block queue manager: host and TLC-write FIFOs of block numbers plus a free
// list, all linked lists over one shared pool of entries.
// Input channel s_*: one word per command. tuser carries op (push, pop,
// drain) and list_select; tdata carries the block number and its flags.
// Output channel m_*: one word per result; tlast marks the final result of
// a command. A drain gives one word per block it returns to the free list,
// or a single EMPTY word if both lists are empty. A push or a pop decides,
// reads the link and block stores, then writes back and registers its
// result; a command that fails its checks registers its result from the
// decide step. A drain repeats read and write-back for each block. Both
// store reads are registered. The next command is accepted the cycle after
// the last result is registered.
// The result sits in an output register, so a stalled receiver does not
// hold the input side until a further result is due; the block then waits
// with tready low.
// Reset (synchronous, active high) chains every entry on the free list at
// once; no clearing pass is needed.
module shared_pool_block_queues
  import sbq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // block_number[15:0], block_erase_busy[16], block_type_invalid[17],
  // block_locked[18], zero fill [23:19]
  input  logic [S_DATA_W-1:0] s_tdata,
  // op[1:0], list_select[3:2]
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // status[2:0], block_out[18:3], lock_set[19], lock_clear[20],
  // host_count[26:21], tlcw_count[32:27], free_count[38:33], zero fill [39]
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbq_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hdl/sbq_ctrl.sv
module sbq_ctrl
  import sbq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (stat.go_push) state_next = S_PUSH_WR;
        else if (stat.go_pop)      state_next = S_POP_WR;
        else if (stat.out_free)    state_next = S_IDLE;
        else                       state_next = S_DECIDE;
      end
      S_PUSH_WR: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_POP_WR: begin
        if (stat.out_free) state_next = stat.pop_last ? S_IDLE : S_DECIDE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      S_DECIDE: begin
        priority if (stat.go_push) cmd.rd_push = 1'b1;
        else if (stat.go_pop)      cmd.rd_pop  = 1'b1;
        else                       cmd.emit_imm = stat.out_free;
      end
      S_PUSH_WR: cmd.commit_push = stat.out_free;
      S_POP_WR:  cmd.commit_pop  = stat.out_free;
      default: ;
    endcase
  end

endmodule

>>> hdl/sbq_dpath.sv
module sbq_dpath
  import sbq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  // Latched input word
  op_t              op_q;
  logic [1:0]       sel_q;
  logic [BLK_W-1:0] blk_q;
  logic             busy_q;
  logic             locked_q;

  // List registers
  logic [IDX_W-1:0] heads [3];
  logic [IDX_W-1:0] tails [3];
  logic [CNT_W-1:0] counts [3];
  logic [IDX_W-1:0] heads_next [3];
  logic [IDX_W-1:0] tails_next [3];
  logic [CNT_W-1:0] counts_next [3];
  logic [1:0]       cur_list;

  // Pool memories
  logic [IDX_W-1:0]      link_mem [QUEUE_SIZE];
  logic [QUEUE_SIZE-1:0] link_vld;
  logic [BLK_W-1:0]      blk_mem [QUEUE_SIZE];
  logic [IDX_W-1:0]      link_rd;
  logic [BLK_W-1:0]      blk_rd;

  logic [1:0]       sel_list;
  logic [1:0]       pick;
  logic [1:0]       tk_list;
  logic [1:0]       app_list;
  logic [IDX_W-1:0] mv_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             lk_we;
  logic             host_empty;
  logic             tlcw_empty;
  status_t          push_sts;
  status_t          pop_sts;
  status_t          imm_sts;
  logic             emit;
  status_t          o_sts;
  logic [BLK_W-1:0] o_blk;
  logic             o_lset;
  logic             o_lclr;
  logic             o_last;

  // Input latch; tuser = op, list_select; tdata = block, busy, type invalid, locked
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q     <= op_t'(s_tuser[1:0]);
      sel_q    <= s_tuser[3:2];
      blk_q    <= s_tdata[BLK_W-1:0];
      busy_q   <= s_tdata[16] | s_tdata[17];
      locked_q <= s_tdata[18];
    end
  end

  // Decision on the latched word
  assign sel_list   = {1'b0, sel_q[0]};
  assign host_empty = (counts[LST_HOST] == '0);
  assign tlcw_empty = (counts[LST_TLCW] == '0);

  always_comb begin
    priority if (sel_q[1])                push_sts = STS_BAD_LIST;
    else if (counts[LST_FREE] == '0)      push_sts = STS_FULL;
    else if (busy_q)                      push_sts = STS_BUSY;
    else if (locked_q)                    push_sts = STS_LOCKED;
    else                                  push_sts = STS_OK;
  end

  always_comb begin
    priority if (sel_q[1])             pop_sts = STS_BAD_LIST;
    else if (counts[sel_list] == '0)   pop_sts = STS_EMPTY;
    else                               pop_sts = STS_OK;
  end

  always_comb begin
    unique case (op_q)
      OP_PUSH:  imm_sts = push_sts;
      OP_POP:   imm_sts = pop_sts;
      OP_DRAIN: imm_sts = STS_EMPTY;
      OP_NONE:  imm_sts = STS_OK;
      default:  imm_sts = STS_OK;
    endcase
  end

  assign pick = (op_q == OP_POP) ? sel_list : (host_empty ? LST_TLCW : LST_HOST);

  assign stat.go_push  = (op_q == OP_PUSH) && (push_sts == STS_OK);
  assign stat.go_pop   = ((op_q == OP_POP) && (pop_sts == STS_OK)) ||
                         ((op_q == OP_DRAIN) && !(host_empty && tlcw_empty));
  assign stat.out_free = !m_tvalid || m_tready;
  assign stat.pop_last = (op_q == OP_POP) ||
                         ((counts[cur_list] == CNT_W'(1)) &&
                          ((cur_list == LST_TLCW) || tlcw_empty));

  // Memory reads, registered
  assign rd_addr = cmd.rd_push ? heads[LST_FREE] : heads[pick];

  always_ff @(posedge clk) begin
    if (cmd.rd_push || cmd.rd_pop) begin
      link_rd <= link_vld[rd_addr] ? link_mem[rd_addr] : rd_addr + IDX_W'(1);
    end
    if (cmd.rd_pop) begin
      blk_rd   <= blk_mem[rd_addr];
      cur_list <= pick;
    end
  end

  // Block number store
  always_ff @(posedge clk) begin
    if (cmd.rd_push) begin
      blk_mem[heads[LST_FREE]] <= blk_q;
    end
  end

  // Move one entry from the taken list to the tail of the appended list
  assign tk_list  = cmd.commit_push ? LST_FREE : cur_list;
  assign app_list = cmd.commit_push ? sel_list : LST_FREE;
  assign mv_idx   = heads[tk_list];

  always_comb begin
    heads_next  = heads;
    tails_next  = tails;
    counts_next = counts;
    lk_we       = 1'b0;
    if (cmd.commit_push || cmd.commit_pop) begin
      heads_next[tk_list]  = link_rd;
      counts_next[tk_list] = counts[tk_list] - CNT_W'(1);
      if (counts[app_list] == '0) begin
        heads_next[app_list] = mv_idx;
      end else begin
        lk_we = 1'b1;
      end
      tails_next[app_list]  = mv_idx;
      counts_next[app_list] = counts[app_list] + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heads[LST_HOST]  <= '0;
      heads[LST_TLCW]  <= '0;
      heads[LST_FREE]  <= '0;
      tails[LST_HOST]  <= '0;
      tails[LST_TLCW]  <= '0;
      tails[LST_FREE]  <= IDX_W'(QUEUE_SIZE - 1);
      counts[LST_HOST] <= '0;
      counts[LST_TLCW] <= '0;
      counts[LST_FREE] <= CNT_W'(QUEUE_SIZE);
    end else begin
      heads  <= heads_next;
      tails  <= tails_next;
      counts <= counts_next;
    end
  end

  // Link store; an unwritten entry points to the next index
  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[tails[app_list]] <= mv_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (lk_we) begin
      link_vld[tails[app_list]] <= 1'b1;
    end
  end

  // Result word
  assign emit = cmd.commit_push || cmd.commit_pop || cmd.emit_imm;

  always_comb begin
    o_sts  = STS_OK;
    o_blk  = NO_BLOCK;
    o_lset = 1'b0;
    o_lclr = 1'b0;
    o_last = 1'b1;
    priority if (cmd.commit_push) begin
      o_lset = 1'b1;
    end else if (cmd.commit_pop) begin
      o_blk  = blk_rd;
      o_lclr = 1'b1;
      o_last = stat.pop_last;
    end else begin
      o_sts = imm_sts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {1'b0,
                  CNT_OUT_W'(counts_next[LST_FREE]),
                  CNT_OUT_W'(counts_next[LST_TLCW]),
                  CNT_OUT_W'(counts_next[LST_HOST]),
                  o_lclr, o_lset, o_blk, o_sts};
      m_tlast <= o_last;
    end
  end

endmodule

>>> hdl/sbq_checker.sv
module sbq_checker
  import sbq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tlast
);

  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // Never ask to set and clear a lock in one word
  a_lock_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[19] && m_tdata[20]))
    else $error("lock set and clear together");

  // A lock set comes only from a good push, which is a single final word
  a_lock_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19] |->
      m_tdata[2:0] == STS_OK && m_tlast && m_tdata[18:3] == NO_BLOCK)
    else $error("lock set on a bad push result");

  // Pool entries are conserved across the three lists
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (m_tdata[26:21] + m_tdata[32:27] + m_tdata[38:33]) == CNT_OUT_W'(QUEUE_SIZE))
    else $error("list counts do not add up to the pool size");

endmodule

bind shared_pool_block_queues sbq_checker u_sbq_checker (.*);
